FILE: rtl/rrr_pkg.sv
// Shared constants and width helpers for the ray reflect/refract unit.
// No dependencies; every other file imports it.
package rrr_pkg;

	// field and datapath widths
	localparam int FIELD_W       = 20;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PROD_W        = 2 * FIELD_W;
	localparam int DOT_W         = PROD_W + 2;
	localparam int PERP_W        = 32;
	localparam int SQ_W          = 2 * PERP_W;
	localparam int ROOT_W        = SQ_W / 2;
	localparam int ACC_W         = 64;

	// clamp bounds
	localparam longint FIELD_MAX = 64'sd524287;
	localparam longint FIELD_MIN = -64'sd524288;
	localparam longint PERP_MAX  = 64'sd2147483647;
	localparam longint PERP_MIN  = -64'sd2147483648;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// width of the rounded dot product
	function automatic int d_w(input int f);
		return DOT_W + 1 - f;
	endfunction

	// width of the clamped cosine term
	function automatic int c_w(input int f);
		return imax(d_w(f) + 1, f + 2);
	endfunction

endpackage

FILE: rtl/rrr_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on rrr_pkg.
module rrr_isqrt (
	input  logic                       clk,
	input  logic [rrr_pkg::SQ_W-1:0]   rad,
	output logic [rrr_pkg::ROOT_W-1:0] root
);
	import rrr_pkg::*;

	localparam int RW = 2 * ROOT_W;

	logic [RW-1:0] rem_q [ROOT_W];
	logic [RW-1:0] res_q [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (2 * (ROOT_W - 1 - k));
		logic [RW-1:0] rem_in;
		logic [RW-1:0] res_in;
		logic [RW-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = rad;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign res_in = res_q[k-1];
		end

		assign trial = res_in + BIT;

		// one compare-subtract step
		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				rem_q[k] <= rem_in - trial;
				res_q[k] <= (res_in >> 1) + BIT;
			end else begin
				rem_q[k] <= rem_in;
				res_q[k] <= res_in >> 1;
			end
		end
	end

	assign root = res_q[ROOT_W-1][ROOT_W-1:0];

endmodule

FILE: rtl/rrr_lane.sv
// One vector component lane: products, rounding, clamps and final select.
// Depends on rrr_pkg; the dot and length merges live in the top level.
module rrr_lane #(
	parameter  int FRAC_BITS = rrr_pkg::FRAC_BITS_DEF,
	localparam int DW        = rrr_pkg::d_w(FRAC_BITS),
	localparam int CW        = rrr_pkg::c_w(FRAC_BITS)
) (
	input  logic                               clk,
	input  logic                               op,
	input  logic signed [rrr_pkg::FIELD_W-1:0] dir,
	input  logic signed [rrr_pkg::FIELD_W-1:0] norm,
	input  logic        [rrr_pkg::FIELD_W-1:0] eta,
	output logic signed [rrr_pkg::PROD_W-1:0]  prod_s1,
	input  logic signed [DW-1:0]               d_s2,
	input  logic signed [CW-1:0]               c_s2,
	output logic        [rrr_pkg::SQ_W-1:0]    sq_s7,
	input  logic        [rrr_pkg::ROOT_W-1:0]  root,
	output logic signed [rrr_pkg::FIELD_W-1:0] res_q,
	output logic                               sat_q
);
	import rrr_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int FW    = FIELD_W;
	localparam int DNW   = DW + FW;
	localparam int RDW   = DNW + 2 - F;
	localparam int RFW   = imax(RDW, FW) + 1;
	localparam int CNW   = CW + FW;
	localparam int RCW   = CNW + 1 - F;
	localparam int WW    = imax(RCW, FW) + 1;
	localparam int EW    = WW + FW + 1;
	localparam int REW   = EW + 1 - F;
	localparam int SNW   = ROOT_W + 1 + FW;
	localparam int RSW   = SNW + 1 - F;
	localparam int OW    = imax(RSW, PERP_W) + 1;
	localparam int CAR_W = 2 + FW + PERP_W + RFW;

	localparam logic [DNW+1:0] HALF_D = {{(DNW+2-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic [CNW:0]   HALF_C = {{(CNW+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic [EW:0]    HALF_E = {{(EW+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic [SNW:0]   HALF_S = {{(SNW+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

	logic                 op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic signed [FW-1:0] v_s1, v_s2, v_s3;
	logic signed [FW-1:0] n_s1, n_s2, n_s3, n_s4, n_s5, n_s6;
	logic        [FW-1:0] eta_s1, eta_s2, eta_s3, eta_s4;
	logic signed [DNW-1:0] dn_s3;
	logic signed [CNW-1:0] cn_s3;
	logic signed [RFW-1:0] refl_s4, refl_s5, refl_s6;
	logic signed [WW-1:0]  w_s4;
	logic signed [EW-1:0]  ew_s5;
	logic signed [PERP_W-1:0] perp_s6;
	logic                  psat_s6;
	logic [CAR_W-1:0]      car_q [ROOT_W+2];

	logic                     op_d, psat_d;
	logic signed [FW-1:0]     n_d;
	logic signed [PERP_W-1:0] perp_d;
	logic signed [RFW-1:0]    refl_d;

	logic signed [SNW-1:0]    sn_s41;
	logic                     op_s41, psat_s41;
	logic signed [PERP_W-1:0] perp_s41;
	logic signed [RFW-1:0]    refl_s41;

	logic [DNW+1:0]        td;
	logic signed [RDW-1:0] rd;
	logic [CNW:0]          tc;
	logic signed [RCW-1:0] rc;
	logic [EW:0]           te;
	logic signed [REW-1:0] re;
	logic signed [ACC_W-1:0] re_w;
	logic signed [ACC_W-1:0] perp_w;
	logic                  perp_clip;
	logic [SNW:0]          ts;
	logic signed [RSW-1:0] rs;
	logic signed [OW-1:0]  rr;
	logic signed [ACC_W-1:0] val_w;
	logic signed [ACC_W-1:0] out_w;
	logic                  out_clip;

	// stages 1 and 2: component product, then wait for the merged dot
	always_ff @(posedge clk) begin
		op_s1   <= op;
		v_s1    <= dir;
		n_s1    <= norm;
		eta_s1  <= eta;
		prod_s1 <= PROD_W'(dir) * PROD_W'(norm);
		op_s2   <= op_s1;
		v_s2    <= v_s1;
		n_s2    <= n_s1;
		eta_s2  <= eta_s1;
	end

	// stage 3: dot times normal and cosine times normal
	always_ff @(posedge clk) begin
		dn_s3  <= DNW'(d_s2) * DNW'(n_s2);
		cn_s3  <= CNW'(c_s2) * CNW'(n_s2);
		op_s3  <= op_s2;
		v_s3   <= v_s2;
		n_s3   <= n_s2;
		eta_s3 <= eta_s2;
	end

	// stage 4 rounding
	always_comb begin
		td = {dn_s3[DNW-1], dn_s3, 1'b0} + HALF_D;
		rd = $signed(td[DNW+1:F]);
		tc = {cn_s3[CNW-1], cn_s3} + HALF_C;
		rc = $signed(tc[CNW:F]);
	end

	// stage 4: reflected vector and refract pre-scale sum
	always_ff @(posedge clk) begin
		refl_s4 <= RFW'(v_s3) - RFW'(rd);
		w_s4    <= WW'(v_s3) + WW'(rc);
		op_s4   <= op_s3;
		n_s4    <= n_s3;
		eta_s4  <= eta_s3;
	end

	// stage 5: scale by the index ratio
	always_ff @(posedge clk) begin
		ew_s5   <= EW'($signed({1'b0, eta_s4})) * EW'(w_s4);
		op_s5   <= op_s4;
		n_s5    <= n_s4;
		refl_s5 <= refl_s4;
	end

	// stage 6 rounding and clamp to 32 bits
	always_comb begin
		te = {ew_s5[EW-1], ew_s5} + HALF_E;
		re = $signed(te[EW:F]);
		re_w = ACC_W'(re);
		perp_clip = 1'b0;
		perp_w = re_w;
		if (re_w > PERP_MAX) begin
			perp_w = PERP_MAX;
			perp_clip = 1'b1;
		end else if (re_w < PERP_MIN) begin
			perp_w = PERP_MIN;
			perp_clip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		perp_s6 <= PERP_W'(perp_w);
		psat_s6 <= perp_clip;
		op_s6   <= op_s5;
		n_s6    <= n_s5;
		refl_s6 <= refl_s5;
	end

	// stage 7: square for the length merge, side data enters the delay line
	always_ff @(posedge clk) begin
		sq_s7    <= $unsigned(SQ_W'(perp_s6) * SQ_W'(perp_s6));
		car_q[0] <= {op_s6, psat_s6, n_s6, perp_s6, refl_s6};
	end

	// hold side data while the length difference and the root are worked out
	for (genvar k = 1; k <= ROOT_W + 1; k++) begin : g_dly
		always_ff @(posedge clk) begin
			car_q[k] <= car_q[k-1];
		end
	end

	assign {op_d, psat_d, n_d, perp_d, refl_d} = car_q[ROOT_W+1];

	// root times normal
	always_ff @(posedge clk) begin
		sn_s41   <= SNW'($signed({1'b0, root})) * SNW'(n_d);
		op_s41   <= op_d;
		psat_s41 <= psat_d;
		perp_s41 <= perp_d;
		refl_s41 <= refl_d;
	end

	// final subtract, select and clamp to the field
	always_comb begin
		ts = {sn_s41[SNW-1], sn_s41} + HALF_S;
		rs = $signed(ts[SNW:F]);
		rr = OW'(perp_s41) - OW'(rs);
		val_w = op_s41 ? ACC_W'(rr) : ACC_W'(refl_s41);
		out_clip = 1'b0;
		out_w = val_w;
		if (val_w > FIELD_MAX) begin
			out_w = FIELD_MAX;
			out_clip = 1'b1;
		end else if (val_w < FIELD_MIN) begin
			out_w = FIELD_MIN;
			out_clip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= FW'(out_w);
		sat_q <= out_clip | (op_s41 & psat_s41);
	end

endmodule

FILE: rtl/ray_reflect_refract_unit.sv
// Ray reflect/refract unit: three component lanes, dot and length merges,
// and a pipelined square root. Depends on rrr_pkg, rrr_lane, rrr_isqrt.
// One request per cycle; busy stays low.
// The path from request to done runs through the 32-stage root pipeline plus ten arithmetic stages.
// Reset clears only the request valid pipeline; done is low out of reset.
module ray_reflect_refract_unit #(
	parameter int FRAC_BITS = rrr_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               op,
	input  logic signed [rrr_pkg::FIELD_W-1:0] dir_x,
	input  logic signed [rrr_pkg::FIELD_W-1:0] dir_y,
	input  logic signed [rrr_pkg::FIELD_W-1:0] dir_z,
	input  logic signed [rrr_pkg::FIELD_W-1:0] norm_x,
	input  logic signed [rrr_pkg::FIELD_W-1:0] norm_y,
	input  logic signed [rrr_pkg::FIELD_W-1:0] norm_z,
	input  logic        [rrr_pkg::FIELD_W-1:0] eta_ratio,
	output logic                               done,
	output logic signed [rrr_pkg::FIELD_W-1:0] out_x,
	output logic signed [rrr_pkg::FIELD_W-1:0] out_y,
	output logic signed [rrr_pkg::FIELD_W-1:0] out_z,
	output logic                               saturated
);
	import rrr_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int DW  = d_w(FRAC_BITS);
	localparam int CW  = c_w(FRAC_BITS);
	localparam int LAT = ROOT_W + 10;

	localparam logic [DOT_W:0]       HALF  = {{(DOT_W+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic signed [CW-1:0] ONE_C = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic [SQ_W-1:0]      ONE2  = {{(SQ_W-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};

	logic [LAT-1:0] vld_q;

	logic signed [FIELD_W-1:0] dir_a  [3];
	logic signed [FIELD_W-1:0] norm_a [3];
	logic signed [PROD_W-1:0]  prod_s1 [3];
	logic        [SQ_W-1:0]    sq_s7 [3];
	logic signed [FIELD_W-1:0] res_q [3];
	logic                      sat_q [3];

	logic signed [DW-1:0] d_s2;
	logic signed [CW-1:0] c_s2;
	logic [SQ_W-1:0]      diff_s8;
	logic [ROOT_W-1:0]    root;

	logic signed [DOT_W-1:0] dot;
	logic [DOT_W:0]          td;
	logic signed [DW-1:0]    d_rnd;
	logic signed [CW-1:0]    negd;
	logic [SQ_W-1:0]         lsq;

	// never stalls: a request is taken every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LAT-1];

	assign dir_a[0]  = dir_x;
	assign dir_a[1]  = dir_y;
	assign dir_a[2]  = dir_z;
	assign norm_a[0] = norm_x;
	assign norm_a[1] = norm_y;
	assign norm_a[2] = norm_z;

	// component lanes
	for (genvar i = 0; i < 3; i++) begin : g_lane
		rrr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk     (clk),
			.op      (op),
			.dir     (dir_a[i]),
			.norm    (norm_a[i]),
			.eta     (eta_ratio),
			.prod_s1 (prod_s1[i]),
			.d_s2    (d_s2),
			.c_s2    (c_s2),
			.sq_s7   (sq_s7[i]),
			.root    (root),
			.res_q   (res_q[i]),
			.sat_q   (sat_q[i])
		);
	end

	// dot merge, rounding and cosine clamp
	always_comb begin
		dot   = DOT_W'(prod_s1[0]) + DOT_W'(prod_s1[1]) + DOT_W'(prod_s1[2]);
		td    = {dot[DOT_W-1], dot} + HALF;
		d_rnd = $signed(td[DOT_W:F]);
		negd  = -CW'(d_rnd);
	end

	always_ff @(posedge clk) begin
		d_s2 <= d_rnd;
		c_s2 <= (negd > ONE_C) ? ONE_C : negd;
	end

	// length merge and distance from one
	assign lsq = sq_s7[0] + sq_s7[1] + sq_s7[2];

	always_ff @(posedge clk) begin
		diff_s8 <= (lsq >= ONE2) ? (lsq - ONE2) : (ONE2 - lsq);
	end

	rrr_isqrt u_isqrt (
		.clk  (clk),
		.rad  (diff_s8),
		.root (root)
	);

	assign out_x     = res_q[0];
	assign out_y     = res_q[1];
	assign out_z     = res_q[2];
	assign saturated = sat_q[0] | sat_q[1] | sat_q[2];

endmodule
